// File: rtl/core/bfi_pkg.sv
`timescale 1ns / 1ps
// Shared widths and types for the Bresenham frame interpolator.
package bfi_pkg;

	localparam int VAL_W   = 8;
	localparam int SPAN_W  = 7;
	localparam int FRAME_W = 16;
	localparam int TAG_W   = 3;
	localparam int CNT_W   = $clog2(VAL_W);

	typedef logic [VAL_W-1:0]   val_t;
	typedef logic [SPAN_W-1:0]  span_t;
	typedef logic [FRAME_W-1:0] frame_t;
	typedef logic [TAG_W-1:0]   tag_t;

	typedef struct packed {
		logic  done;
		val_t  quot;
		span_t rem;
	} div_res_t;

endpackage

// File: rtl/core/bfi_div.sv
`timescale 1ns / 1ps
// Bit-serial restoring divider: one quotient bit per cycle.
module bfi_div (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  bfi_pkg::val_t    dividend,
	input  bfi_pkg::span_t   divisor,
	output bfi_pkg::div_res_t res
);
	import bfi_pkg::*;

	logic              busy_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	val_t              quo_q;
	span_t             rem_q;
	span_t             dvs_q;

	logic [VAL_W-1:0]  trial;
	logic [VAL_W:0]    diff;
	logic              ge;

	assign trial = {rem_q, quo_q[VAL_W-1]};
	assign diff  = {1'b0, trial} - {2'b00, dvs_q};
	assign ge    = ~diff[VAL_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(VAL_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[VAL_W-2:0], ge};
			rem_q <= ge ? diff[SPAN_W-1:0] : trial[SPAN_W-1:0];
		end
	end

	assign res.done = done_q;
	assign res.quot = quo_q;
	assign res.rem  = rem_q;

endmodule

// File: rtl/core/bresenham_frame_interpolator.sv
`timescale 1ns / 1ps
// Bresenham frame interpolator: serial divide, then one result beat per frame.
// An accepted span runs through the serial divider (S_DIV), then S_EMIT registers its beats.
// Throughput: one result per cycle while out_stall lets beats through; in_stall holds the
// input from acceptance until the last beat is sent, so a new span waits for the last one.
// Spans below 2 or above MAX_SPAN are accepted and give no result.
// Reset: arst_n clears the sequencer and output valid; payload is not reset.
module bresenham_frame_interpolator #(
	parameter int MAX_SPAN = 64
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	input  bfi_pkg::val_t   start_value,
	input  logic signed [7:0] delta,
	input  bfi_pkg::span_t  span_width,
	input  bfi_pkg::frame_t base_frame,
	input  bfi_pkg::tag_t   table_tag,
	output logic            out_valid,
	input  logic            out_stall,
	output bfi_pkg::tag_t   out_tag,
	output bfi_pkg::frame_t out_frame,
	output bfi_pkg::val_t   out_value,
	output logic            last
);
	import bfi_pkg::*;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_DIV  = 2'd1;
	localparam logic [1:0] S_EMIT = 2'd2;
	localparam logic [VAL_W-1:0] MAX_W = VAL_W'(MAX_SPAN);

	logic [1:0] state_q;
	logic       neg_q;
	val_t       start_q;
	span_t      width_q;
	frame_t     frame_q;
	tag_t       tag_q;
	val_t       quot_q;
	span_t      rem_q;
	val_t       val_q;
	val_t       err_q;
	span_t      left_q;

	logic       out_valid_q;
	tag_t       out_tag_q;
	frame_t     out_frame_q;
	val_t       out_value_q;
	logic       last_q;

	logic       accept;
	logic       span_ok;
	val_t       mag;
	val_t       quot_s;
	div_res_t   div_res;
	val_t       err_sum;
	logic       corr;
	val_t       err_nx;
	val_t       val_adj;
	logic       fire;

	assign in_stall = (state_q != S_IDLE);
	assign accept   = in_valid && !in_stall;
	assign span_ok  = (span_width >= SPAN_W'(2)) && ({1'b0, span_width} <= MAX_W);
	assign mag      = delta[VAL_W-1] ? VAL_W'(-delta) : VAL_W'(delta);

	bfi_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (accept && span_ok),
		.dividend (mag),
		.divisor  (span_width),
		.res      (div_res)
	);

	assign quot_s  = neg_q ? VAL_W'(-div_res.quot) : div_res.quot;
	assign err_sum = err_q + {1'b0, rem_q};
	assign corr    = err_sum >= {1'b0, width_q};
	assign err_nx  = corr ? err_sum - {1'b0, width_q} : err_sum;

	always_comb begin
		val_adj = val_q;
		if (corr) begin
			if (neg_q)
				val_adj = val_q - 1'b1;
			else if (val_q != '0)
				val_adj = val_q + 1'b1;
		end
	end

	assign fire = (state_q == S_EMIT) && (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (fire)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept && span_ok)
						state_q <= S_DIV;
				end
				S_DIV: begin
					if (div_res.done)
						state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (fire && left_q == SPAN_W'(1))
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			neg_q   <= delta[VAL_W-1];
			start_q <= start_value;
			width_q <= span_width;
			frame_q <= base_frame;
			tag_q   <= table_tag;
			left_q  <= span_width - 1'b1;
		end
		if (state_q == S_DIV && div_res.done) begin
			quot_q <= quot_s;
			rem_q  <= div_res.rem;
			val_q  <= start_q + quot_s;
			err_q  <= '0;
		end
		if (fire) begin
			out_tag_q   <= tag_q;
			out_frame_q <= frame_q + 1'b1;
			out_value_q <= val_adj;
			last_q      <= (left_q == SPAN_W'(1));
			frame_q     <= frame_q + 1'b1;
			val_q       <= val_adj + quot_q;
			err_q       <= err_nx;
			left_q      <= left_q - 1'b1;
		end
	end

	assign out_valid = out_valid_q;
	assign out_tag   = out_tag_q;
	assign out_frame = out_frame_q;
	assign out_value = out_value_q;
	assign last      = last_q;

endmodule

// File: rtl/core/bfi_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the Bresenham frame interpolator, bound to the top level.
module bfi_checker #(
	parameter int MAX_SPAN = 64
) (
	input logic            clk,
	input logic            arst_n,
	input logic            in_valid,
	input logic            in_stall,
	input bfi_pkg::val_t   start_value,
	input logic signed [7:0] delta,
	input bfi_pkg::span_t  span_width,
	input bfi_pkg::frame_t base_frame,
	input bfi_pkg::tag_t   table_tag,
	input logic            out_valid,
	input logic            out_stall,
	input bfi_pkg::tag_t   out_tag,
	input bfi_pkg::frame_t out_frame,
	input bfi_pkg::val_t   out_value,
	input logic            last
);
	import bfi_pkg::*;

	localparam logic [VAL_W-1:0] MAX_W = VAL_W'(MAX_SPAN);

	// a real span holds the input side
	a_span_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && span_width >= SPAN_W'(2) && {1'b0, span_width} <= MAX_W
		|=> in_stall)
		else $error("span accepted but input not held");

	// short span frees the input at once
	a_short_span: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && span_width < SPAN_W'(2)
		|=> !in_stall)
		else $error("short span did not complete at once");

	// no new item while a span is mid-flight
	a_mid_span: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last |-> in_stall)
		else $error("input free before last beat");

	// beats of a span come back to back when not stalled
	a_no_gap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !last |=> out_valid && out_frame == $past(out_frame) + 1'b1)
		else $error("gap or frame skip inside span");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_value) && $stable(out_frame)
		&& $stable(out_tag) && $stable(last))
		else $error("stalled result beat changed");

endmodule

bind bresenham_frame_interpolator bfi_checker #(.MAX_SPAN(MAX_SPAN)) u_bfi_checker (.*);

// File: test/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for bresenham_frame_interpolator: queued spans in, predicted points out.
module tb;
	import bfi_pkg::*;

	localparam int SPAN_LIMIT   = 64;
	localparam int CYCLE_LIMIT  = 1000000;
	localparam int TAIL_CYCLES  = 40;
	localparam int HOLD_AFTER   = 60;
	localparam int HOLD_CYCLES  = 400;
	localparam int RANDOM_SPANS = 225;

	typedef struct {
		val_t              start;
		logic signed [7:0] change;
		span_t             width;
		frame_t            base;
		tag_t              tag;
	} span_item_t;

	typedef struct {
		tag_t   tag;
		frame_t frame;
		val_t   value;
		logic   last;
	} point_t;

	logic              clk         = 1'b0;
	logic              arst_n      = 1'b0;
	logic              in_valid    = 1'b0;
	logic              in_stall;
	val_t              start_value = '0;
	logic signed [7:0] delta       = '0;
	span_t             span_width  = '0;
	frame_t            base_frame  = '0;
	tag_t              table_tag   = '0;
	logic              out_valid;
	logic              out_stall   = 1'b0;
	tag_t              out_tag;
	frame_t            out_frame;
	val_t              out_value;
	logic              last;

	bresenham_frame_interpolator #(.MAX_SPAN(SPAN_LIMIT)) dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.start_value(start_value),
		.delta      (delta),
		.span_width (span_width),
		.base_frame (base_frame),
		.table_tag  (table_tag),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_tag    (out_tag),
		.out_frame  (out_frame),
		.out_value  (out_value),
		.last       (last)
	);

	span_item_t pending_q[$];
	point_t     expected_points[$];
	int         errors      = 0;
	int         spans_sent  = 0;
	int         spans_total = 0;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// walk the span exactly as the hardware should and queue every point
	task automatic interpolate_span(input span_item_t s);
		logic        neg;
		logic [7:0]  mag;
		int unsigned w;
		int unsigned q;
		int unsigned r;
		int unsigned err;
		val_t        v;
		point_t      p;
		neg = s.change[7];
		mag = neg ? 8'd0 - 8'(s.change) : 8'(s.change);
		w = s.width;
		if (w < 2 || w > SPAN_LIMIT)
			return;
		q = mag / w;
		r = mag % w;
		if (neg)
			q = (256 - q) & 8'hFF;
		err = 0;
		v = s.start + val_t'(q);
		for (int step = 1; step < w; step++) begin
			err += r;
			if (err >= w) begin
				err -= w;
				if (neg)
					v = v - 8'd1;
				else if (v != 8'd0)
					v = v + 8'd1;
			end
			p.tag   = s.tag;
			p.frame = s.base + frame_t'(step);
			p.value = v;
			p.last  = (step == w - 1);
			expected_points.push_back(p);
			v = v + val_t'(q);
		end
	endtask

	task automatic add_span(input val_t start, input logic signed [7:0] change,
			input span_t width, input frame_t base, input tag_t tag);
		span_item_t s;
		s.start  = start;
		s.change = change;
		s.width  = width;
		s.base   = base;
		s.tag    = tag;
		pending_q.push_back(s);
	endtask

	task automatic check_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			errors++;
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
		end
	endtask

	// sender
	span_item_t cur_span;
	int         tx_gap     = 0;
	bit         tx_idle_en = 1'b1;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!(in_valid && in_stall)) begin
			if (in_valid) begin
				interpolate_span(cur_span);
				spans_sent++;
				if (spans_sent % 48 == 0)
					tx_idle_en = !tx_idle_en;
			end
			if (tx_gap > 0) begin
				tx_gap--;
				in_valid <= 1'b0;
			end else if (pending_q.size() > 0) begin
				cur_span = pending_q.pop_front();
				tx_gap = tx_idle_en ? $urandom_range(0, 7) : 0;
				in_valid    <= 1'b1;
				start_value <= cur_span.start;
				delta       <= cur_span.change;
				span_width  <= cur_span.width;
				base_frame  <= cur_span.base;
				table_tag   <= cur_span.tag;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// long receiver hold-off once HOLD_AFTER spans have been accepted, so the input backs up
	logic hold_on   = 1'b0;
	int   hold_left = 0;
	int   hold_seen = 0;
	bit   hold_used = 1'b0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_on <= 1'b0;
		end else begin
			if (in_valid && !in_stall)
				hold_seen++;
			if (!hold_used && hold_seen >= HOLD_AFTER) begin
				hold_used = 1'b1;
				hold_left = HOLD_CYCLES;
				hold_on <= 1'b1;
			end else if (hold_left > 0) begin
				hold_left--;
				if (hold_left == 0)
					hold_on <= 1'b0;
			end
		end
	end

	// receiver and checker
	int     rx_gap     = 0;
	bit     rx_idle_en = 1'b1;
	int     beats_seen = 0;
	point_t want;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_points.size() == 0) begin
					errors++;
					$display("%0t: unexpected beat, expected none, actual tag %0h frame %0h value %0h last %0b",
						$time, out_tag, out_frame, out_value, last);
				end else begin
					want = expected_points.pop_front();
					check_field("out_tag", want.tag, out_tag);
					check_field("out_frame", want.frame, out_frame);
					check_field("out_value", want.value, out_value);
					check_field("last", want.last, last);
				end
				beats_seen++;
				if (beats_seen % 150 == 0)
					rx_idle_en = !rx_idle_en;
				rx_gap = rx_idle_en ? $urandom_range(0, 7) : 0;
			end
			out_stall <= hold_on || (rx_gap > 0);
			if (rx_gap > 0)
				rx_gap--;
		end
	end

	int cycles = 0;

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("[bresenham_frame_interpolator] ERROR");
			$finish;
		end
	end

	initial begin
		int n;
		int sel;
		span_t w;
		val_t st;
		n = 0;
		// directed: short, oversized and boundary spans, delta extremes, wraps
		add_span(8'd10, 8'sd5, 7'd0, 16'd100, 3'd0);
		add_span(8'd10, 8'sd5, 7'd1, 16'd100, 3'd1);
		add_span(8'd10, 8'sd5, 7'd2, 16'd200, 3'd2);
		add_span(8'd20, 8'sd100, 7'd65, 16'd300, 3'd3);
		add_span(8'd20, 8'sd100, 7'd127, 16'd300, 3'd4);
		add_span(8'd0, 8'sd127, 7'd64, 16'd400, 3'd5);
		add_span(8'd255, -8'sd128, 7'd64, 16'd500, 3'd6);
		add_span(8'd128, -8'sd128, 7'd2, 16'd600, 3'd7);
		add_span(8'd128, -8'sd128, 7'd3, 16'd700, 3'd0);
		add_span(8'd5, -8'sd128, 7'd7, 16'd800, 3'd1);
		add_span(8'd0, 8'sd2, 7'd3, 16'd900, 3'd2);
		add_span(8'd0, 8'sd7, 7'd5, 16'd910, 3'd3);
		add_span(8'd0, -8'sd1, 7'd4, 16'd920, 3'd4);
		add_span(8'd255, 8'sd9, 7'd4, 16'd930, 3'd5);
		add_span(8'd77, 8'sd0, 7'd6, 16'd940, 3'd6);
		add_span(8'd250, 8'sd127, 7'd3, 16'hFFFE, 3'd7);
		add_span(8'd1, -8'sd127, 7'd5, 16'hFFFF, 3'd7);
		add_span(8'd33, 8'sd63, 7'd64, 16'hFFF0, 3'd0);
		add_span(8'd200, -8'sd33, 7'd16, 16'd0, 3'd1);
		add_span(8'd64, 8'sd1, 7'd64, 16'h8000, 3'd2);
		// random spans: mostly short, some long, some that the block rejects
		while (n < RANDOM_SPANS) begin
			sel = $urandom_range(0, 99);
			if (sel < 10)
				w = ($urandom_range(0, 1) == 0) ? span_t'($urandom_range(0, 1))
					: span_t'($urandom_range(65, 127));
			else if (sel < 20)
				w = span_t'($urandom_range(17, 64));
			else
				w = span_t'($urandom_range(2, 16));
			if (w >= 2 && w <= SPAN_LIMIT)
				n++;
			st = ($urandom_range(0, 3) == 0) ? 8'd0 : val_t'($urandom_range(0, 255));
			add_span(st, 8'($urandom_range(0, 255)), w, frame_t'($urandom_range(0, 65535)),
				tag_t'($urandom_range(0, 7)));
		end
		spans_total = pending_q.size();
		repeat (9) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;
		wait (spans_sent == spans_total);
		while (expected_points.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("[bresenham_frame_interpolator] OK");
		else
			$display("[bresenham_frame_interpolator] ERROR");
		$finish;
	end

endmodule
